@@ src/pcbe_pkg.sv @@
// Shared types, constants and helpers for the cubic path evaluator.
package pcbe_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_EVAL   = 1'b1;

    // one stored path point, nine coordinates
    typedef struct packed {
        logic signed [31:0] tz;
        logic signed [31:0] ty;
        logic signed [31:0] tx;
        logic signed [31:0] hz;
        logic signed [31:0] hy;
        logic signed [31:0] hx;
        logic signed [31:0] az;
        logic signed [31:0] ay;
        logic signed [31:0] ax;
    } t_point;

    // clamp a wide signed value to 32 bits
    function automatic logic [31:0] sat32(input logic signed [71:0] v);
        logic [31:0] r;
        if (v > 72'sd2147483647) r = 32'h7FFF_FFFF;
        else if (v < -72'sd2147483648) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

@@ src/piecewise_cubic_bezier_evaluator.sv @@
// Top level: point table in memory and a sequenced blend datapath.
// Sequence per item: an append goes straight to the output state; an evaluate with
// fewer than two points leaves after the first read, one at time one or above after
// the wait state, and a full evaluate makes two reads and six multiply steps first.
// One item is in flight at a time; the next is taken as the result is taken.
// Reset clears the point count and control; the memory contents stay undefined.
module piecewise_cubic_bezier_evaluator
    import pcbe_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // anchor_x,y,z, handle_x,y,z, turn_x,y,z, time_fraction, pad to 312 bits
    input  logic [311:0] s_axis_tdata,
    // op
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x,y,z, rot_x,y,z, pad to 192 bits
    output logic [191:0] m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);
    localparam int WW = FRAC_BITS + 3;  // weight width, up to 3*one

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD0  = 7'b0000010,
        S_RD1  = 7'b0000100,
        S_WT   = 7'b0001000,
        S_WMUL = 7'b0010000,
        S_ACC  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // point memory, one wide word per point
    t_point mem [MAX_POINTS];
    t_point r_rd;
    logic [AW-1:0] r_raddr;
    logic [CW-1:0] r_count;

    logic [16:0] r_time;
    t_point      r_p0, r_p1;
    logic [AW-1:0] r_seg;
    logic [FRAC_BITS-1:0] r_t;
    logic [FRAC_BITS:0] r_u;
    logic [2:0]  r_step;
    logic [WW-1:0] r_uu, r_tt, r_w0, r_w1, r_w2, r_w3;
    logic        r_vld;
    logic [191:0] r_data;
    logic [1:0]  r_stat;

    t_point in_pt;
    assign in_pt = s_axis_tdata[287:0];

    logic take;
    assign s_axis_tready = (r_state == S_IDLE) && (!r_vld || m_axis_tready);
    assign take = s_axis_tvalid && s_axis_tready;

    // memory write on append, registered read
    always_ff @(posedge i_clk) begin
        if (take && s_axis_tuser == OP_APPEND && r_count < CNT_MAX)
            mem[r_count[AW-1:0]] <= in_pt;
        r_rd <= mem[r_raddr];
    end

    // segment lookup from time
    logic [16+CW-1:0] scaled;
    logic [CW-1:0] last;
    logic [CW-1:0] segw;
    assign last = r_count - CW'(1);
    assign scaled = (16+CW)'(r_time) * (16+CW)'(last);
    always_comb begin
        segw = scaled[16+CW-1:16];
        if (segw >= last) segw = last - CW'(1);
    end

    // shared weight multiplier
    logic [WW-1:0] ma, mb;
    logic [2*WW-1:0] mp;
    logic [WW-1:0] mr;
    assign mp = ma * mb;
    assign mr = WW'((mp + (2*WW)'(1 << (FRAC_BITS-1))) >> FRAC_BITS);
    always_comb begin
        ma = '0; mb = '0;
        case (r_step)
            3'd0: begin ma = WW'(r_u); mb = WW'(r_u); end
            3'd1: begin ma = WW'(r_t); mb = WW'(r_t); end
            3'd2: begin ma = r_uu; mb = WW'(r_u); end
            3'd3: begin ma = r_uu; mb = WW'(r_t); end
            3'd4: begin ma = r_tt; mb = WW'(r_u); end
            3'd5: begin ma = r_tt; mb = WW'(r_t); end
            default: ;
        endcase
    end

    // blend one coordinate of position and rotation
    function automatic logic [31:0] bpos(
        input logic signed [31:0] p0, input logic signed [31:0] h0,
        input logic signed [31:0] h1, input logic signed [31:0] p1,
        input logic first,
        input logic [WW-1:0] w0, input logic [WW-1:0] w1,
        input logic [WW-1:0] w2, input logic [WW-1:0] w3);
        logic signed [33:0] c0;
        logic signed [71:0] acc;
        c0 = first ? 34'(h0) : (34'(p0) <<< 1) - 34'(h0);
        acc = 72'($signed({1'b0, w0})) * 72'(p0) + 72'($signed({1'b0, w1})) * 72'(c0)
            + 72'($signed({1'b0, w2})) * 72'(h1) + 72'($signed({1'b0, w3})) * 72'(p1)
            + 72'(1 << (FRAC_BITS-1));
        return sat32(acc >>> FRAC_BITS);
    endfunction

    function automatic logic [31:0] brot(
        input logic signed [31:0] a, input logic signed [31:0] b,
        input logic [FRAC_BITS-1:0] t);
        logic signed [71:0] d;
        d = 72'(33'(b) - 33'(a)) * 72'($signed({1'b0, t})) + 72'(1 << (FRAC_BITS-1));
        return sat32(72'(a) + (d >>> FRAC_BITS));
    endfunction

    logic first;
    assign first = (r_seg == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (take) n_state = (s_axis_tuser == OP_EVAL) ? S_RD0 : S_OUT;
            S_RD0:  n_state = (r_count < CW'(2)) ? S_OUT : S_RD1;
            S_RD1:  n_state = S_WT;
            S_WT:   n_state = r_time[16] ? S_OUT : S_WMUL;
            S_WMUL: if (r_step == 3'd5) n_state = S_ACC;
            S_ACC:  n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT) r_vld <= 1'b1;
            else if (m_axis_tready) r_vld <= 1'b0;
            case (r_state)
                S_IDLE: if (take) begin
                    r_time <= s_axis_tdata[304:288];
                    r_data <= '0;
                    if (s_axis_tuser == OP_APPEND && r_count >= CNT_MAX) r_stat <= ST_FULL;
                    else r_stat <= ST_OK;
                    if (s_axis_tuser == OP_APPEND && r_count < CNT_MAX)
                        r_count <= r_count + CW'(1);
                end
                S_RD0: begin
                    r_seg   <= segw[AW-1:0];
                    r_raddr <= r_time[16] ? last[AW-1:0] : segw[AW-1:0];
                    r_t <= FRAC_BITS'(({24'd0, scaled[15:0]} << FRAC_BITS) >> 16);
                    if (r_count < CW'(2)) r_stat <= ST_SHORT;
                end
                S_RD1: begin
                    r_raddr <= r_seg + AW'(1);
                    r_u <= (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(r_t);
                    r_step <= 3'd0;
                end
                S_WT: begin
                    r_p0 <= r_rd;
                    if (r_time[16]) r_data <= {96'd0, r_rd.az, r_rd.ay, r_rd.ax};
                end
                S_WMUL: begin
                    if (r_step == 3'd0) r_p1 <= r_rd;
                    case (r_step)
                        3'd0: r_uu <= mr;
                        3'd1: r_tt <= mr;
                        3'd2: r_w0 <= mr;
                        3'd3: r_w1 <= WW'(3 * mr);
                        3'd4: r_w2 <= WW'(3 * mr);
                        default: r_w3 <= mr;
                    endcase
                    r_step <= r_step + 3'd1;
                end
                S_ACC: begin
                    r_data <= {
                        brot(r_p0.tz, r_p1.tz, r_t),
                        brot(r_p0.ty, r_p1.ty, r_t),
                        brot(r_p0.tx, r_p1.tx, r_t),
                        bpos(r_p0.az, r_p0.hz, r_p1.hz, r_p1.az, first,
                             r_w0, r_w1, r_w2, r_w3),
                        bpos(r_p0.ay, r_p0.hy, r_p1.hy, r_p1.ay, first,
                             r_w0, r_w1, r_w2, r_w3),
                        bpos(r_p0.ax, r_p0.hx, r_p1.hx, r_p1.ax, first,
                             r_w0, r_w1, r_w2, r_w3)};
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = r_stat;

endmodule

@@ test/piecewise_cubic_bezier_evaluator_tb.sv @@
// Testbench for the cubic path evaluator: scoreboard against a behavioural path model.
module piecewise_cubic_bezier_evaluator_tb;
    import pcbe_pkg::*;

    localparam int NPTS = 16;
    localparam int FB   = 16;
    localparam int WDOG = 20000;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] pos [3];
        logic signed [31:0] rot [3];
    } t_path_result;

    int errors = 0;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // path model plus queue of expected results
    class t_path_scoreboard;
        logic signed [31:0] anc [NPTS][3];
        logic signed [31:0] hdl [NPTS][3];
        logic signed [31:0] trn [NPTS][3];
        int count;
        t_path_result pending[$];

        function void clear();
            count = 0;
            pending.delete();
        endfunction

        function automatic logic signed [31:0] clamp32(longint v);
            if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        endfunction

        // floor division by 2^FB
        function automatic longint floor_fb(longint v);
            return v >>> FB;
        endfunction

        function automatic longint rnd(longint x);
            return (x + (64'sd1 << (FB - 1))) >>> FB;
        endfunction

        // note an accepted input and predict its result
        function void note_input(logic op, logic signed [31:0] f [9], logic [16:0] tf);
            t_path_result r;
            longint t, u, uu, tt, w0, w1, w2, w3, p0, c0, c1, p1, a, b;
            int seg, last;
            r.status = ST_OK;
            for (int k = 0; k < 3; k++) begin
                r.pos[k] = 0;
                r.rot[k] = 0;
            end
            if (op == OP_APPEND) begin
                if (count >= NPTS) r.status = ST_FULL;
                else begin
                    for (int k = 0; k < 3; k++) begin
                        anc[count][k] = f[k];
                        hdl[count][k] = f[3 + k];
                        trn[count][k] = f[6 + k];
                    end
                    count++;
                end
            end else if (count < 2) begin
                r.status = ST_SHORT;
            end else begin
                last = count - 1;
                if (tf >= 17'd65536) begin
                    for (int k = 0; k < 3; k++) r.pos[k] = anc[last][k];
                end else begin
                    seg = int'((longint'(tf) * last) >> 16);
                    if (seg >= last) seg = last - 1;
                    t = (longint'(tf) * last) & 64'hFFFF;
                    u = (64'sd1 << FB) - t;
                    uu = rnd(u * u);
                    tt = rnd(t * t);
                    w0 = rnd(uu * u);
                    w1 = 3 * rnd(uu * t);
                    w2 = 3 * rnd(u * tt);
                    w3 = rnd(tt * t);
                    for (int k = 0; k < 3; k++) begin
                        p0 = anc[seg][k];
                        c0 = hdl[seg][k];
                        c1 = hdl[seg + 1][k];
                        p1 = anc[seg + 1][k];
                        if (seg != 0) c0 = 2 * p0 - c0;
                        r.pos[k] = clamp32(floor_fb(w0 * p0 + w1 * c0 + w2 * c1 + w3 * p1
                                                    + (64'sd1 << (FB - 1))));
                        a = trn[seg][k];
                        b = trn[seg + 1][k];
                        r.rot[k] = clamp32(a + floor_fb((b - a) * t + (64'sd1 << (FB - 1))));
                    end
                end
            end
            pending = {pending, r};
        endfunction

        // compare a result with the oldest expectation
        task check_result(logic [191:0] d, logic [1:0] st);
            t_path_result e;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing expected", 32'd0, 32'd0);
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) report_mismatch("status", 32'(st), 32'(e.status));
            for (int k = 0; k < 3; k++) begin
                if (d[32*k +: 32] !== e.pos[k]) report_mismatch("pos", d[32*k +: 32], e.pos[k]);
                if (d[96 + 32*k +: 32] !== e.rot[k])
                    report_mismatch("rot", d[96 + 32*k +: 32], e.rot[k]);
            end
        endtask
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [311:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [191:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_items = 0, n_evals = 0, n_results = 0;
    t_path_scoreboard path_sb;

    always #1 i_clk = ~i_clk;

    piecewise_cubic_bezier_evaluator dut (.*);

    // check results and run the watchdog at each rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                path_sb.check_result(m_axis_tdata, m_axis_tuser);
                n_results++;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG) begin
                $display("Watchdog expired");
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(65536 * 64)) - 32'sd2097152;
        endcase
    endfunction

    function automatic logic [16:0] rand_time();
        case ($urandom_range(9))
            0: return 17'd65536;
            1: return 17'($urandom_range(131071, 65537));
            2: return 17'd0;
            3: return 17'd65535;
            default: return 17'($urandom_range(65535));
        endcase
    endfunction

    // present one item at a falling edge, possibly after random idle gaps, and hold until the transfer
    task automatic send_item(logic op, logic signed [31:0] f [9], logic [16:0] tf);
        logic [311:0] d;
        d = '0;
        for (int k = 0; k < 9; k++) d[32*k +: 32] = f[k];
        d[288 +: 17] = tf;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1;
        do @(posedge i_clk); while (!s_axis_tready);
        path_sb.note_input(op, f, tf);
        n_items++;
        if (op == OP_EVAL) n_evals++;
    endtask

    task automatic append_point(bit extreme);
        logic signed [31:0] f [9];
        for (int k = 0; k < 9; k++)
            f[k] = extreme ? (k[0] ? 32'h7FFF_FFFF : 32'h8000_0000) : rand_coord();
        send_item(OP_APPEND, f, 17'($urandom));
    endtask

    task automatic eval_at(logic [16:0] tf);
        logic signed [31:0] f [9];
        for (int k = 0; k < 9; k++) f[k] = $urandom;
        send_item(OP_EVAL, f, tf);
    endtask

    // drop the sender and wait for every expected result
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 0;
        while (path_sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // drain and clear the table by reset-free means: not possible, so table is
    // refilled only after a fresh reset at start; later paths just fill to full
    initial begin
        path_sb = new();
        path_sb.clear();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: too few points, extremes, time edges
        eval_at(17'd0);
        append_point(1);
        eval_at(17'd32768);
        append_point(1);
        eval_at(17'd0);
        eval_at(17'd32768);
        eval_at(17'd65535);
        eval_at(17'd65536);
        eval_at(17'h1FFFF);
        append_point(0);
        eval_at(17'd49152);
        eval_at(17'd16384);
        drain();

        // random: evaluations over a table growing to full, then full-table appends
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (int i = 0; i < 440; i++) begin
                if ($urandom_range(99) < (path_sb.count < NPTS ? 12 : 4)) append_point(0);
                else eval_at(rand_time());
                if (i == 200) drain();
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        $display("Covered %0d items (%0d evaluations, %0d results), table at %0d points",
                 n_items, n_evals, n_results, path_sb.count);
        $display("Idle patterns: none, sender 81%%, receiver 81%%, both 8%%");
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
src/pcbe_pkg.sv
src/piecewise_cubic_bezier_evaluator.sv
test/piecewise_cubic_bezier_evaluator_tb.sv
